// ===== hw/rtl/jbl_pkg.sv =====
// jbl_pkg: shared types, codes and helpers of the jitter buffer loss tracker
// used by jbl_front, jbl_engine and the top level; no dependencies
`timescale 1ns / 1ps
package jbl_pkg;

  localparam int BUFFER_DEPTH_DEF    = 16;
  localparam int DELIVERED_DEPTH_DEF = 64;

  localparam logic [1:0] ACT_SENT   = 2'd0;
  localparam logic [1:0] ACT_RECV   = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [2:0] KIND_RELEASED  = 3'd0;
  localparam logic [2:0] KIND_ACCEPTED  = 3'd1;
  localparam logic [2:0] KIND_DROP_LATE = 3'd2;
  localparam logic [2:0] KIND_DROP_FULL = 3'd3;
  localparam logic [2:0] KIND_STATS     = 3'd4;
  localparam logic [2:0] KIND_SENT      = 3'd5;

  localparam logic [1:0] CFG_REL_WIN   = 2'd0;
  localparam logic [1:0] CFG_PRUNE_WIN = 2'd1;
  localparam logic [1:0] CFG_BYPASS    = 2'd2;

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 208;

  typedef struct packed {
    logic [1:0]         act;
    logic signed [31:0] seq;
    logic [15:0]        size;
    logic [47:0]        arr;
    logic [47:0]        now;
  } item_t;

  typedef struct packed {
    logic [47:0] rel_win;
    logic [47:0] prune_win;
    logic        bypass;
  } cfg_t;

  // whether the age of a stored time against now exceeds the window, later times count as zero age
  function automatic logic exceeds(input logic [47:0] now, input logic [47:0] t,
                                   input logic [47:0] w);
    logic [47:0] age;
    age = now - t;
    return (now > t) && (age > w);
  endfunction

endpackage

// ===== hw/rtl/jbl_ram.sv =====
// jbl_ram: generic one-write one-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module jbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hw/rtl/jbl_front.sv =====
// jbl_front: input word capture, action filter and a two-entry item queue
// depends on jbl_pkg
`timescale 1ns / 1ps
module jbl_front import jbl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [1:0]            in_tuser,
  output item_t                 q_item,
  output logic                  q_valid,
  input  logic                  q_ready
);

  item_t      ent_r [2];
  logic       rd_ptr_r;
  logic       wr_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;
  item_t      in_item;

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = ent_r[rd_ptr_r];
  // unused action code carries no work and is dropped here
  assign push      = in_tvalid && in_tready && (in_tuser != ACT_NONE);
  assign pop       = q_valid && q_ready;

  always_comb begin
    in_item.act  = in_tuser;
    in_item.seq  = $signed(in_tdata[31:0]);
    in_item.size = in_tdata[47:32];
    in_item.arr  = in_tdata[95:48];
    in_item.now  = in_tdata[143:96];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wr_ptr_r] <= in_item;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/jbl_engine.sv =====
// jbl_engine: back end sequencer, jitter buffer, delivered ring and result list
// depends on jbl_pkg and jbl_ram
`timescale 1ns / 1ps
module jbl_engine import jbl_pkg::*; #(
  parameter int BUFFER_DEPTH    = BUFFER_DEPTH_DEF,
  parameter int DELIVERED_DEPTH = DELIVERED_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  item_t                  item,
  input  logic                   item_valid,
  output logic                   item_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [2:0]             out_tuser,
  output logic                   out_tlast
);

  localparam int BAW = $clog2(BUFFER_DEPTH);
  localparam int BCW = $clog2(BUFFER_DEPTH + 1);
  localparam int DAW = $clog2(DELIVERED_DEPTH);
  localparam int DCW = $clog2(DELIVERED_DEPTH + 1);
  localparam int RD  = BUFFER_DEPTH + 1;
  localparam int RIW = $clog2(RD);
  localparam int RAW = $clog2(RD + 1);
  localparam logic [DAW:0] DD_W = (DAW + 1)'(DELIVERED_DEPTH);
  localparam logic [DCW-1:0] DD_C = DCW'(DELIVERED_DEPTH);
  localparam logic [BCW-1:0] BD_C = BCW'(BUFFER_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_REL_SCAN, S_REL_POP, S_INS_START, S_INS_RD, S_INS_CMP, S_INS_WR,
    S_RECV_FIN, S_PR_RD, S_PR_CMP, S_EMIT
  } state_t;

  state_t             state_r;
  state_t             ret_r;
  item_t              it_r;
  logic signed [31:0] buf_seq_r  [BUFFER_DEPTH];
  logic [47:0]        buf_time_r [BUFFER_DEPTH];
  logic [BCW-1:0]     buf_cnt_r;
  logic [BCW-1:0]     scan_r;
  logic [BCW-1:0]     cut_r;
  logic [DAW-1:0]     head_r;
  logic [DCW-1:0]     dcnt_r;
  logic signed [31:0] dlast_r;
  logic [DAW-1:0]     j_r;
  logic signed [31:0] ins_seq_r;
  logic [47:0]        ins_time_r;
  logic [63:0]        sent_r;
  logic [63:0]        recv_r;
  logic [2:0]         res_kind_r [RD];
  logic signed [31:0] res_seq_r  [RD];
  logic [RAW-1:0]     res_n_r;
  logic [RAW-1:0]     emit_r;
  logic [32:0]        exp_r;
  logic               sv_r;

  logic               ram_we;
  logic [DAW-1:0]     ram_waddr;
  logic [79:0]        ram_wdata;
  logic [DAW-1:0]     ram_raddr;
  logic [79:0]        ram_rdata;
  logic signed [31:0] rd_seq;
  logic [47:0]        rd_time;

  logic               dfull;
  logic [DAW-1:0]     head_eff;
  logic [DCW-1:0]     cnt_eff;
  logic               direct;
  logic [BAW-1:0]     sidx;
  logic [BUFFER_DEPTH-1:0] le;
  logic [32:0]        span;
  logic               last_res;
  logic [RIW-1:0]     wr_idx;
  logic [RIW-1:0]     eidx;

  // logical ring position to ram address
  function automatic logic [DAW-1:0] phys(input logic [DAW-1:0] h,
                                          input logic [DAW-1:0] j);
    logic [DAW:0] s;
    s = {1'b0, h} + {1'b0, j};
    if (s >= DD_W) begin
      s = s - DD_W;
    end
    return s[DAW-1:0];
  endfunction

  jbl_ram #(.WIDTH(80), .DEPTH(DELIVERED_DEPTH)) u_dlv_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_seq   = $signed(ram_rdata[31:0]);
  assign rd_time  = ram_rdata[79:32];
  assign dfull    = (dcnt_r == DD_C);
  assign head_eff = dfull ? phys(head_r, DAW'(1)) : head_r;
  assign cnt_eff  = dfull ? (DD_C - DCW'(1)) : dcnt_r;
  // new entry lands at the end when the list is empty or it is not below the newest
  assign direct   = (cnt_eff == '0) || (ins_seq_r >= dlast_r);
  assign sidx     = BAW'(scan_r - BCW'(1));
  assign span     = {dlast_r[31], dlast_r} - {rd_seq[31], rd_seq} + 33'd1;
  assign wr_idx   = RIW'(res_n_r);
  assign eidx     = RIW'(emit_r);
  assign last_res = (emit_r == (res_n_r - RAW'(1)));

  always_comb begin
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      le[i] = (BCW'(i) < buf_cnt_r) && (buf_seq_r[i] <= it_r.seq);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys(head_r, j_r);
    ram_wdata = {ins_time_r, ins_seq_r};
    ram_raddr = head_r;
    case (state_r)
      S_INS_START: begin
        ram_we    = direct;
        ram_waddr = phys(head_eff, DAW'(cnt_eff));
      end
      S_INS_RD: begin
        ram_raddr = phys(head_r, j_r - DAW'(1));
      end
      S_INS_CMP: begin
        // shift the larger entry up one place, or drop the new one in
        ram_we = 1'b1;
        if (rd_seq > ins_seq_r) begin
          ram_wdata = ram_rdata;
        end
      end
      S_INS_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      buf_cnt_r <= '0;
      head_r    <= '0;
      dcnt_r    <= '0;
      sent_r    <= '0;
      recv_r    <= '0;
      res_n_r   <= '0;
      emit_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (item_valid) begin
            it_r    <= item;
            res_n_r <= '0;
            emit_r  <= '0;
            sv_r    <= 1'b0;
            exp_r   <= '0;
            scan_r  <= buf_cnt_r;
            case (item.act)
              ACT_SENT: begin
                sent_r        <= sent_r + 64'(item.size);
                res_kind_r[0] <= KIND_SENT;
                res_seq_r[0]  <= item.seq;
                res_n_r       <= RAW'(1);
                state_r       <= S_EMIT;
              end
              ACT_RECV: begin
                if (cfg.bypass) begin
                  recv_r        <= recv_r + 64'(item.size);
                  ins_seq_r     <= item.seq;
                  ins_time_r    <= item.arr;
                  res_kind_r[0] <= KIND_ACCEPTED;
                  res_seq_r[0]  <= item.seq;
                  res_n_r       <= RAW'(1);
                  ret_r         <= S_EMIT;
                  state_r       <= S_INS_START;
                end else begin
                  state_r <= S_REL_SCAN;
                end
              end
              ACT_UPDATE: begin
                state_r <= S_REL_SCAN;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_REL_SCAN: begin
          // search down from the newest slot for the last entry past the window
          if (scan_r == '0) begin
            state_r <= (it_r.act == ACT_RECV) ? S_RECV_FIN : S_PR_RD;
          end else if (exceeds(it_r.now, buf_time_r[sidx], cfg.rel_win)) begin
            cut_r   <= scan_r;
            state_r <= S_REL_POP;
          end else begin
            scan_r <= scan_r - BCW'(1);
          end
        end
        S_REL_POP: begin
          if (cut_r == '0) begin
            state_r <= (it_r.act == ACT_RECV) ? S_RECV_FIN : S_PR_RD;
          end else begin
            ins_seq_r          <= buf_seq_r[0];
            ins_time_r         <= buf_time_r[0];
            res_kind_r[wr_idx] <= KIND_RELEASED;
            res_seq_r[wr_idx]  <= buf_seq_r[0];
            res_n_r            <= res_n_r + RAW'(1);
            for (int i = 0; i < BUFFER_DEPTH - 1; i++) begin
              buf_seq_r[i]  <= buf_seq_r[i+1];
              buf_time_r[i] <= buf_time_r[i+1];
            end
            buf_cnt_r <= buf_cnt_r - BCW'(1);
            cut_r     <= cut_r - BCW'(1);
            ret_r     <= S_REL_POP;
            state_r   <= S_INS_START;
          end
        end
        S_INS_START: begin
          // a full list gives up its lowest entry first
          head_r <= head_eff;
          dcnt_r <= cnt_eff + DCW'(1);
          j_r    <= DAW'(cnt_eff);
          if (direct) begin
            dlast_r <= ins_seq_r;
            state_r <= ret_r;
          end else begin
            state_r <= S_INS_RD;
          end
        end
        S_INS_RD: begin
          state_r <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (rd_seq > ins_seq_r) begin
            j_r     <= j_r - DAW'(1);
            state_r <= (j_r == DAW'(1)) ? S_INS_WR : S_INS_RD;
          end else begin
            state_r <= ret_r;
          end
        end
        S_INS_WR: begin
          state_r <= ret_r;
        end
        S_RECV_FIN: begin
          recv_r            <= recv_r + 64'(it_r.size);
          res_seq_r[wr_idx] <= it_r.seq;
          res_n_r           <= res_n_r + RAW'(1);
          if ((dcnt_r != '0) && (it_r.seq < dlast_r)) begin
            res_kind_r[wr_idx] <= KIND_DROP_LATE;
          end else if (buf_cnt_r >= BD_C) begin
            res_kind_r[wr_idx] <= KIND_DROP_FULL;
          end else begin
            res_kind_r[wr_idx] <= KIND_ACCEPTED;
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
              if (!le[i]) begin
                if ((i == 0) || le[(i == 0) ? 0 : i - 1]) begin
                  buf_seq_r[i]  <= it_r.seq;
                  buf_time_r[i] <= it_r.arr;
                end else begin
                  buf_seq_r[i]  <= buf_seq_r[(i == 0) ? 0 : i - 1];
                  buf_time_r[i] <= buf_time_r[(i == 0) ? 0 : i - 1];
                end
              end
            end
            buf_cnt_r <= buf_cnt_r + BCW'(1);
          end
          state_r <= S_EMIT;
        end
        S_PR_RD: begin
          if (dcnt_r == '0) begin
            res_kind_r[wr_idx] <= KIND_STATS;
            res_seq_r[wr_idx]  <= '0;
            res_n_r            <= res_n_r + RAW'(1);
            state_r            <= S_EMIT;
          end else begin
            state_r <= S_PR_CMP;
          end
        end
        S_PR_CMP: begin
          if (exceeds(it_r.now, rd_time, cfg.prune_win)) begin
            head_r  <= phys(head_r, DAW'(1));
            dcnt_r  <= dcnt_r - DCW'(1);
            state_r <= S_PR_RD;
          end else begin
            // head entry now holds the lowest sequence still in the window
            res_kind_r[wr_idx] <= KIND_STATS;
            res_seq_r[wr_idx]  <= '0;
            res_n_r            <= res_n_r + RAW'(1);
            if (dcnt_r >= DCW'(2)) begin
              sv_r  <= 1'b1;
              exp_r <= span;
            end
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_tready) begin
            if (last_res) begin
              state_r <= S_IDLE;
            end else begin
              emit_r <= emit_r + RAW'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign item_ready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EMIT);
  assign out_tuser  = res_kind_r[eidx];
  assign out_tlast  = last_res;

  always_comb begin
    out_tdata          = '0;
    out_tdata[31:0]    = res_seq_r[eidx];
    out_tdata[38:32]   = 7'(dcnt_r);
    out_tdata[71:39]   = (res_kind_r[eidx] == KIND_STATS) ? exp_r : 33'd0;
    out_tdata[72]      = (res_kind_r[eidx] == KIND_STATS) && sv_r;
    out_tdata[136:73]  = sent_r;
    out_tdata[200:137] = recv_r;
  end

endmodule

// ===== hw/rtl/jitter_buffer_loss_tracker.sv =====
// a sent record goes straight to output; a received or update word scans the buffer one
// slot a cycle, each release or insert walks the delivered ram entry by entry, pruning
// steps through the ring from its head, and results leave one word a cycle while
// out_tready is high; the engine takes no new item until the last result of the one before
// has left; reset (rst_n low, synchronous) empties buffer, ring, queue and byte totals,
// clears the window registers and bypass; ram contents stay undefined
`timescale 1ns / 1ps
module jitter_buffer_loss_tracker import jbl_pkg::*; #(
  parameter int BUFFER_DEPTH    = BUFFER_DEPTH_DEF,
  parameter int DELIVERED_DEPTH = DELIVERED_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [47:0]            cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // seq_no, size_bytes, arrival_time_us, now_us
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_seq_no, received_count, expected_count, stats_valid, sent_total,
  // received_total, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // kind
  output logic [2:0]             out_tuser,
  output logic                   out_tlast
);

  cfg_t  cfg_r;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REL_WIN:   cfg_r.rel_win   <= cfg_wdata;
        CFG_PRUNE_WIN: cfg_r.prune_win <= cfg_wdata;
        CFG_BYPASS:    cfg_r.bypass    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  jbl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready)
  );

  jbl_engine #(
    .BUFFER_DEPTH    (BUFFER_DEPTH),
    .DELIVERED_DEPTH (DELIVERED_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
